// ----- sv/omr_pkg.sv -----
// shared types and constants for the overwriting message ring
// no dependencies; imported by omr_store, the top level and the testbench
`timescale 1ns / 1ps

package omr_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OP_W       = 2;
  localparam int CMD_W      = 8;
  localparam int SEQ_W      = 16;
  localparam int DATA_IN_W  = 32;
  localparam int PENDING_W  = 4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [PTR_W:0]   ptr_wide_t;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [CMD_W-1:0]     command;
    logic [SEQ_W-1:0]     sequence_req;
    logic [DATA_IN_W-1:0] data;
  } in_t;

  typedef struct packed {
    logic                 read_valid;
    logic [CMD_W-1:0]     read_command;
    logic [SEQ_W-1:0]     read_sequence;
    logic [DATA_IN_W-1:0] read_data;
    logic                 duplicate_found;
    logic [PENDING_W-1:0] pending_count;
  } out_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [SEQ_W-1:0]      seq;
    logic [DATA_WIDTH-1:0] dat;
  } entry_t;

  // memory port control from the sequencer
  typedef struct packed {
    logic wr_en;
    ptr_t wr_addr;
    logic rd_en;
    ptr_t rd_addr;
  } mem_ctrl_t;

  // ring pointer step with wrap at DEPTH
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = ptr_t'(p + ptr_t'(1));
    end
    return r;
  endfunction

endpackage

// ----- sv/omr_store.sv -----
// message slot memory with one write port, one registered read port
// and the shared command/sequence compare; depends on omr_pkg
`timescale 1ns / 1ps

module omr_store
  import omr_pkg::*;
(
  input  logic              clk,
  input  mem_ctrl_t         ctrl,
  input  entry_t            wr_entry,
  input  logic [CMD_W-1:0]  key_cmd,
  input  logic [SEQ_W-1:0]  key_seq,
  output entry_t            rd_entry,
  output logic              hit
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_entry <= mem[ctrl.rd_addr];
    end
  end

  // compare on the entry just read
  assign hit = (rd_entry.cmd == key_cmd) && (rd_entry.seq == key_seq);

endmodule

// ----- sv/overwriting_message_ring_with_dup_check.sv -----
// overwriting message ring with duplicate check, top level; uses omr_pkg, omr_store
// one request at a time: push, op code 3, and pops or queries on an empty ring
// go from ISSUE straight to RESP; a pop on a stored message passes through SCAN
// a query walks stored messages one per cycle in SCAN and stops at the first hit
// the single memory read port and its compare set the query time
// synchronous active-high reset empties the ring; slot contents are left as they are
`timescale 1ns / 1ps

module overwriting_message_ring_with_dup_check
  import omr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_req,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_rsp
);

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state;

  // ring pointers and fill count
  ptr_t wp;
  ptr_t rp;
  ptr_t cnt;

  // latched request and result under construction
  in_t  req;
  out_t res;

  // scan position: address whose data is on the read port, and entries left
  ptr_t scan_idx;
  ptr_t scan_left;

  mem_ctrl_t ctrl;
  entry_t    wr_entry;
  entry_t    rd_entry;
  logic      hit;

  logic is_full;
  logic is_empty;

  assign is_full  = (cnt == ptr_t'(DEPTH - 1));
  assign is_empty = (cnt == '0);

  assign in_ready = (state == ST_IDLE);

  // push writes at the write pointer; keep only the low DATA_WIDTH bits
  assign wr_entry.cmd = req.command;
  assign wr_entry.seq = req.sequence_req;
  assign wr_entry.dat = DATA_WIDTH'(req.data);

  always_comb begin
    ctrl.wr_en   = (state == ST_ISSUE) && (req.operation == OP_PUSH);
    ctrl.wr_addr = wp;
    // first read at the oldest entry, then walk forward one slot a cycle
    ctrl.rd_en   = (state == ST_ISSUE) || (state == ST_SCAN);
    ctrl.rd_addr = (state == ST_ISSUE) ? rp : ptr_inc(scan_idx);
  end

  omr_store u_store (
    .clk      (clk),
    .ctrl     (ctrl),
    .wr_entry (wr_entry),
    .key_cmd  (req.command),
    .key_seq  (req.sequence_req),
    .rd_entry (rd_entry),
    .hit      (hit)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // drained result clears unless a new one is loaded below
      if (out_valid && out_ready && (state != ST_RESP)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          case (req.operation)
            OP_PUSH: begin
              wp <= ptr_inc(wp);
              // full ring drops the oldest message
              if (is_full) begin
                rp <= ptr_inc(rp);
              end else begin
                cnt <= ptr_t'(cnt + ptr_t'(1));
              end
              state <= ST_RESP;
            end
            OP_POP, OP_QUERY: begin
              state <= is_empty ? ST_RESP : ST_SCAN;
            end
            default: begin
              state <= ST_RESP;
            end
          endcase
        end

        ST_SCAN: begin
          if (req.operation == OP_POP) begin
            rp    <= ptr_inc(rp);
            cnt   <= ptr_t'(cnt - ptr_t'(1));
            state <= ST_RESP;
          end else if (hit || (scan_left == ptr_t'(1))) begin
            state <= ST_RESP;
          end
        end

        ST_RESP: begin
          // output register free or being drained this cycle
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req <= in_req;
        end
      end

      ST_ISSUE: begin
        res       <= '0;
        scan_idx  <= rp;
        scan_left <= cnt;
      end

      ST_SCAN: begin
        if (req.operation == OP_POP) begin
          res.read_valid    <= 1'b1;
          res.read_command  <= rd_entry.cmd;
          res.read_sequence <= rd_entry.seq;
          res.read_data     <= DATA_IN_W'(rd_entry.dat);
        end else begin
          if (hit) begin
            res.duplicate_found <= 1'b1;
          end
          scan_idx  <= ptr_inc(scan_idx);
          scan_left <= ptr_t'(scan_left - ptr_t'(1));
        end
      end

      ST_RESP: begin
        if (!out_valid || out_ready) begin
          // count already reflects this request
          out_rsp <= out_t'({res[$bits(out_t)-1:PENDING_W], PENDING_W'(cnt)});
        end
      end

      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  // fill count never exceeds DEPTH-1
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= ptr_t'(DEPTH - 1))
    else $error("ring count above capacity");

  // pointers and count agree
  a_ptr_cnt: assert property (@(posedge clk) disable iff (rst)
    (wp >= rp) ? ((wp - rp) == cnt)
               : ((ptr_wide_t'(wp) + ptr_wide_t'(DEPTH) - ptr_wide_t'(rp))
                  == ptr_wide_t'(cnt)))
    else $error("ring pointers disagree with count");

  // a query walk never runs past the stored entries
  a_scan_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (req.operation == OP_QUERY) |-> (scan_left != '0))
    else $error("query walk with no entries left");

  // push, pop and op code 3 never enter the walk except a pop on a stored message
  a_scan_op: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((req.operation == OP_POP) || (req.operation == OP_QUERY)))
    else $error("walk entered for a push or no-op request");
`endif

endmodule

// ----- tb/tb_overwriting_message_ring_with_dup_check.sv -----
// self-checking testbench for the overwriting message ring with duplicate check
// depends on omr_pkg and overwriting_message_ring_with_dup_check, which also needs omr_store
// a shadow ring predicts every result, random gaps and a long stall stress both handshakes
`timescale 1ns / 1ps

module tb_overwriting_message_ring_with_dup_check;
  import omr_pkg::*;

  // op code 3 is unused by the block and must act as a no-op
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int IDLE_MAX    = 12;    // longest per-request gap on either side
  localparam int HOLD_CYCLES = 80;    // long receiver stall for the pressure test
  localparam int STALL_LIMIT = 1000;  // cycles with no handshake before giving up
  localparam int DRAIN_WAIT  = 24;    // covers the longest query walk
  localparam int PRINT_MAX   = 40;    // keep the log short on a bad run

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_req;
  logic out_valid;
  logic out_ready;
  out_t out_rsp;

  // shadow copy of the ring contents and pointers
  entry_t shadow_slot [DEPTH];
  int     shadow_wr;
  int     shadow_rd;

  // results predicted for accepted requests, oldest first
  out_t ring_results_due [$];

  int error_count;
  bit tx_idle_en;
  bit rx_idle_en;
  int rx_hold_cycles;

  overwriting_message_ring_with_dup_check i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // shadow ring
  // ---------------------------------------------------------------------------

  // pointer step with wrap at DEPTH
  function automatic int ring_step(int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  // number of stored messages, at most DEPTH-1
  function automatic int ring_fill();
    return (shadow_wr - shadow_rd + DEPTH) % DEPTH;
  endfunction

  // apply one request to the shadow ring and return the result it must produce
  function automatic out_t predict_ring_op(in_t r);
    out_t o;
    int   idx;
    int   n;
    o = '0;
    case (r.operation)
      OP_PUSH: begin
        shadow_slot[shadow_wr].cmd = r.command;
        shadow_slot[shadow_wr].seq = r.sequence_req;
        shadow_slot[shadow_wr].dat = r.data[DATA_WIDTH-1:0];
        shadow_wr = ring_step(shadow_wr);
        // ring was full: the oldest message is overwritten
        if (shadow_wr == shadow_rd) begin
          shadow_rd = ring_step(shadow_rd);
        end
      end
      OP_POP: begin
        // empty ring leaves every read field at zero
        if (ring_fill() != 0) begin
          o.read_valid    = 1'b1;
          o.read_command  = shadow_slot[shadow_rd].cmd;
          o.read_sequence = shadow_slot[shadow_rd].seq;
          o.read_data     = DATA_IN_W'(shadow_slot[shadow_rd].dat);
          shadow_rd       = ring_step(shadow_rd);
        end
      end
      OP_QUERY: begin
        // walk only the valid entries, oldest to newest
        n   = ring_fill();
        idx = shadow_rd;
        for (int i = 0; i < n; i++) begin
          if (shadow_slot[idx].cmd == r.command && shadow_slot[idx].seq == r.sequence_req) begin
            o.duplicate_found = 1'b1;
          end
          idx = ring_step(idx);
        end
      end
      default: begin
        // no-op: state untouched, only the count is reported
      end
    endcase
    o.pending_count = PENDING_W'(ring_fill());
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // request building
  // ---------------------------------------------------------------------------

  function automatic in_t pack_request(logic [OP_W-1:0] op, logic [CMD_W-1:0] cmd,
                                       logic [SEQ_W-1:0] seq, logic [DATA_IN_W-1:0] dat);
    in_t r;
    r.operation    = op;
    r.command      = cmd;
    r.sequence_req = seq;
    r.data         = dat;
    return r;
  endfunction

  // random content; small pools for command and sequence so pushes repeat and
  // queries often hit; queries mostly aim at a stored message or a near miss
  function automatic in_t shape_request(logic [OP_W-1:0] op);
    in_t    r;
    int     n;
    int     pick;
    entry_t e;
    r.operation    = op;
    r.command      = $urandom_range(0, 1) ? CMD_W'($urandom_range(0, 3)) : CMD_W'($urandom);
    r.sequence_req = $urandom_range(0, 1) ? SEQ_W'($urandom_range(0, 7)) : SEQ_W'($urandom);
    r.data         = $urandom;
    n = ring_fill();
    if (op == OP_QUERY && n != 0) begin
      pick = $urandom_range(0, 9);
      e = shadow_slot[(shadow_rd + $urandom_range(0, n - 1)) % DEPTH];
      if (pick < 5) begin
        r.command      = e.cmd;
        r.sequence_req = e.seq;
      end else if (pick < 7) begin
        // same command, one sequence bit off
        r.command      = e.cmd;
        r.sequence_req = e.seq ^ (SEQ_W'(1) << $urandom_range(0, SEQ_W - 1));
      end else if (pick < 8) begin
        // same sequence, one command bit off
        r.command      = e.cmd ^ (CMD_W'(1) << $urandom_range(0, CMD_W - 1));
        r.sequence_req = e.seq;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_MAX) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // send one request: optional idle gap, then hold valid until accepted;
  // the prediction is taken at the accepting edge
  task automatic send_request(in_t r);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_ready !== 1'b1);
    ring_results_due.push_back(predict_ring_op(r));
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // result checker: compares each accepted result with the oldest prediction
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (ring_results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = ring_results_due.pop_front();
          check_field("read_valid", out_rsp.read_valid, want.read_valid);
          check_field("read_command", out_rsp.read_command, want.read_command);
          check_field("read_sequence", out_rsp.read_sequence, want.read_sequence);
          check_field("read_data", out_rsp.read_data, want.read_data);
          check_field("duplicate_found", out_rsp.duplicate_found, want.duplicate_found);
          check_field("pending_count", out_rsp.pending_count, want.pending_count);
        end
      end
    end
  end

  // receiver: random hold-off before each result, or one long stall on request
  initial begin
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      gap = rx_idle_en ? $urandom_range(0, IDLE_MAX) : 0;
      if (rx_hold_cycles > 0) begin
        gap            = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // watchdog: too long without any handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // pop and query on an empty ring, and the unused op code
  task automatic test_empty_ring();
    send_request(pack_request(OP_POP, 8'h00, 16'h0000, 32'h0000_0000));
    send_request(pack_request(OP_QUERY, 8'h00, 16'h0000, 32'h0000_0000));
    send_request(pack_request(OP_NOP, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    wait_all_results();
  endtask

  // fill past capacity so the oldest message is lost, then probe the ends
  task automatic test_full_ring_overwrite();
    send_request(pack_request(OP_PUSH, 8'h5A, 16'h1234, 32'hA5A5_A5A5));  // gets dropped
    send_request(pack_request(OP_PUSH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(pack_request(OP_PUSH, 8'h00, 16'h0000, 32'h0000_0000));
    for (int i = 0; i < 13; i++) begin
      send_request(pack_request(OP_PUSH, CMD_W'(i + 1), SEQ_W'(16'h0100 + i), $urandom));
    end
    // dropped message must be gone, oldest and newest still present
    send_request(pack_request(OP_QUERY, 8'h5A, 16'h1234, 32'h0000_0000));
    send_request(pack_request(OP_QUERY, 8'hFF, 16'hFFFF, 32'h0000_0000));
    send_request(pack_request(OP_QUERY, 8'h0D, 16'h010C, 32'h0000_0000));
    send_request(pack_request(OP_NOP, 8'h00, 16'h0000, 32'h0000_0000));
    // all-ones then all-zeros messages come back first
    send_request(pack_request(OP_POP, 8'h00, 16'h0000, 32'h0000_0000));
    send_request(pack_request(OP_POP, 8'h00, 16'h0000, 32'h0000_0000));
    wait_all_results();
  endtask

  // receiver stalls for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    logic [OP_W-1:0] op;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (30) begin
      op = logic'($urandom_range(0, 2) == 0) ? OP_POP : ($urandom_range(0, 1) ? OP_PUSH : OP_QUERY);
      send_request(shape_request(op));
    end
    wait_all_results();
  endtask

  // segments with different op mixes so the ring fills, drains and wraps;
  // some segments run with no idling on either side
  task automatic test_random_traffic(int segments, int per_segment);
    int              push_w;
    int              pop_w;
    int              p;
    logic [OP_W-1:0] op;
    for (int s = 0; s < segments; s++) begin
      case ($urandom_range(0, 3))
        0:       begin push_w = 70; pop_w = 10; end  // fill and overwrite
        1:       begin push_w = 15; pop_w = 65; end  // drain, pops on empty
        2:       begin push_w = 30; pop_w = 20; end  // query heavy
        default: begin push_w = 40; pop_w = 30; end
      endcase
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat (per_segment) begin
        p = $urandom_range(0, 99);
        if (p < 3) begin
          op = OP_NOP;
        end else if (p < 3 + push_w) begin
          op = OP_PUSH;
        end else if (p < 3 + push_w + pop_w) begin
          op = OP_POP;
        end else begin
          op = OP_QUERY;
        end
        send_request(shape_request(op));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_req         = '0;
    error_count    = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    rx_hold_cycles = 0;
    shadow_wr      = 0;
    shadow_rd      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_ring();
    test_full_ring_overwrite();
    test_output_backpressure();
    test_random_traffic(28, 25);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/omr_pkg.sv
sv/omr_store.sv
sv/overwriting_message_ring_with_dup_check.sv
tb/tb_overwriting_message_ring_with_dup_check.sv
